// File: hw/rtl/dual_motor_velocity_pid_pwm_macros.svh
// Assertion macros shared by the RTL modules.
`ifndef DUAL_MOTOR_VELOCITY_PID_PWM_MACROS_SVH
`define DUAL_MOTOR_VELOCITY_PID_PWM_MACROS_SVH
`ifndef SYNTHESIS
// Check a property at each rising clock edge, disabled while reset is high.
`define DMV_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check a property at each rising clock edge, reset included.
`define DMV_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DMV_ASSERT(label, clk, rst, prop, msg)
`define DMV_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// File: hw/rtl/dmv_pkg.sv
package dmv_pkg;

   localparam int GAIN_W      = 24;
   localparam int SPEED_W     = 16;
   localparam int ERR_W       = SPEED_W + 1;
   localparam int DIFF_W      = ERR_W + 1;
   localparam int ACC_W       = 32;
   localparam int DRIVE_W     = 16;
   localparam int LIMIT_W     = 15;
   localparam int CENTER_W    = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_KP_A,
      CSR_KI_A,
      CSR_KD_A,
      CSR_KP_B,
      CSR_KI_B,
      CSR_KD_B,
      CSR_DRIVE_LIMIT,
      CSR_PWM_CENTER
   } csr_index_type;

   typedef struct packed {
      logic signed [GAIN_W-1:0] kp;
      logic signed [GAIN_W-1:0] ki;
      logic signed [GAIN_W-1:0] kd;
   } gains_type;

   typedef struct packed {
      gains_type [1:0]       gains;
      logic [LIMIT_W-1:0]    drive_limit;
      logic [CENTER_W-1:0]   pwm_center;
   } cfg_type;

   typedef struct packed {
      logic                      channel;
      logic signed [SPEED_W-1:0] encoder;
      logic signed [SPEED_W-1:0] target;
   } req_item_type;

   typedef struct packed {
      logic                      out_channel;
      logic signed [DRIVE_W-1:0] drive;
      logic [CENTER_W-1:0]       compare_one;
      logic [CENTER_W-1:0]       compare_two;
   } rsp_item_type;

   localparam gains_type GAINS_RESET = '{
      kp: GAIN_W'(7680),
      ki: GAIN_W'(0),
      kd: GAIN_W'(153600)
   };

   localparam cfg_type CFG_RESET = '{
      gains:       '{GAINS_RESET, GAINS_RESET},
      drive_limit: LIMIT_W'(7100),
      pwm_center:  CENTER_W'(7200)
   };

endpackage

// File: hw/rtl/dmv_req_if.sv
interface dmv_req_if import dmv_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic                      channel;
   logic signed [SPEED_W-1:0] encoder;
   logic signed [SPEED_W-1:0] target;

   modport source (output valid, output channel, output encoder, output target, input ready);
   modport sink (input valid, input channel, input encoder, input target, output ready);
endinterface

// File: hw/rtl/dmv_rsp_if.sv
interface dmv_rsp_if import dmv_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic                      out_channel;
   logic signed [DRIVE_W-1:0] drive;
   logic [CENTER_W-1:0]       compare_one;
   logic [CENTER_W-1:0]       compare_two;

   modport source (
      output valid, output out_channel, output drive, output compare_one,
      output compare_two, input ready
   );
   modport sink (
      input valid, input out_channel, input drive, input compare_one,
      input compare_two, output ready
   );
endinterface

// File: hw/rtl/dmv_csr_if.sv
interface dmv_csr_if import dmv_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/dual_motor_velocity_pid_pwm.sv
// Flow: each item is held in the request register; the PID update, clamp
// and bridge mapping run in one pass to the result register, which takes
// it once free. Throughput: one item per cycle unless rsp_bus stalls.
// Reset: synchronous; clears both pipeline stages and all per-channel state,
// and loads the gain, limit and center registers with their defaults.
`include "dual_motor_velocity_pid_pwm_macros.svh"

module dual_motor_velocity_pid_pwm import dmv_pkg::*; #(
   parameter int CHANNELS = 2
) (
   input logic       clock,
   input logic       reset,
   dmv_req_if.sink   req_bus,
   dmv_rsp_if.source rsp_bus,
   dmv_csr_if.sink   csr_bus
);

   logic         in_valid_ff;
   logic         in_valid_in;
   req_item_type item_ff;
   req_item_type item_in;
   logic         out_valid_ff;
   logic         out_valid_in;
   rsp_item_type res_ff;
   rsp_item_type res_in;
   rsp_item_type result;
   cfg_type      cfg;
   logic         advance;
   logic         chan_ok;
   logic         take_in;

   dmv_csr u_csr (
      .clock (clock),
      .reset (reset),
      .csr   (csr_bus),
      .cfg   (cfg)
   );

   dmv_core #(
      .CHANNELS (CHANNELS)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item_ff),
      .cfg     (cfg),
      .result  (result)
   );

   always_comb begin
      advance       = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
      req_bus.ready = !in_valid_ff || advance;
      chan_ok       = (CHANNELS > 1) || !req_bus.channel;
      take_in       = req_bus.valid && req_bus.ready && chan_ok;
      in_valid_in   = take_in || (in_valid_ff && !advance);
      out_valid_in  = advance || (out_valid_ff && !rsp_bus.ready);

      item_in = item_ff;
      if (req_bus.valid && req_bus.ready) begin
         item_in.channel = req_bus.channel;
         item_in.encoder = req_bus.encoder;
         item_in.target  = req_bus.target;
      end
      res_in = advance ? result : res_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      item_ff <= item_in;
      res_ff  <= res_in;
   end

   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.out_channel = res_ff.out_channel;
   assign rsp_bus.drive       = res_ff.drive;
   assign rsp_bus.compare_one = res_ff.compare_one;
   assign rsp_bus.compare_two = res_ff.compare_two;

   `DMV_ASSERT_NR(a_reset_empties, clock, reset |=> !in_valid_ff && !out_valid_ff, "pipeline not empty after reset")
   `DMV_ASSERT(a_input_held, clock, reset, in_valid_ff && !advance |=> in_valid_ff, "pending item lost from request register")
   `DMV_ASSERT(a_result_follows, clock, reset, advance |=> out_valid_ff && res_ff == $past(result), "result not registered after advance")
   `DMV_ASSERT(a_full_stalls_input, clock, reset, in_valid_ff && out_valid_ff && !rsp_bus.ready |-> !req_bus.ready, "request taken while both stages full")

endmodule

// File: hw/rtl/dmv_csr.sv
module dmv_csr import dmv_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   dmv_csr_if.sink    csr,
   output cfg_type    cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr.ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr.valid) begin
         unique case (csr_index_type'(csr.index))
            CSR_KP_A:        cfg_in.gains[0].kp   = csr.data;
            CSR_KI_A:        cfg_in.gains[0].ki   = csr.data;
            CSR_KD_A:        cfg_in.gains[0].kd   = csr.data;
            CSR_KP_B:        cfg_in.gains[1].kp   = csr.data;
            CSR_KI_B:        cfg_in.gains[1].ki   = csr.data;
            CSR_KD_B:        cfg_in.gains[1].kd   = csr.data;
            CSR_DRIVE_LIMIT: cfg_in.drive_limit   = csr.data[LIMIT_W-1:0];
            CSR_PWM_CENTER:  cfg_in.pwm_center    = csr.data[CENTER_W-1:0];
            default:         cfg_in               = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: hw/rtl/dmv_core.sv
`include "dual_motor_velocity_pid_pwm_macros.svh"

module dmv_core import dmv_pkg::*; #(
   parameter int CHANNELS = 2
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         advance,
   input  req_item_type item,
   input  cfg_type      cfg,
   output rsp_item_type result
);

   localparam int ChW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int PRD_W = GAIN_W + ACC_W;
   localparam int TRM_W = PRD_W - 8;
   localparam int SUM_W = TRM_W + 2;

   logic signed [ERR_W-1:0] last_error_ff [CHANNELS];
   logic signed [ACC_W-1:0] error_sum_ff  [CHANNELS];
   logic signed [ACC_W-1:0] accum_ff      [CHANNELS];

   logic [ChW-1:0]            ch_idx;
   gains_type                 gains;
   logic signed [ERR_W-1:0]   err;
   logic signed [DIFF_W-1:0]  diff;
   logic signed [SUM_W-1:0]   sum_wide;
   logic signed [ACC_W-1:0]   error_sum_in;
   logic signed [PRD_W-1:0]   prod_p;
   logic signed [PRD_W-1:0]   prod_i;
   logic signed [PRD_W-1:0]   prod_d;
   logic signed [SUM_W-1:0]   accum_wide;
   logic signed [ACC_W-1:0]   accum_in;
   logic signed [DRIVE_W-1:0] lim_s;
   logic signed [ACC_W-1:0]   lim_w;
   logic signed [DRIVE_W-1:0] drive;
   logic [DRIVE_W-1:0]        mag;
   logic signed [CENTER_W:0]  far;
   logic [CENTER_W-1:0]       far_sat;
   logic                      far_on_one;

   // Drop the eight fraction bits, rounding toward zero.
   function automatic logic signed [TRM_W-1:0] trunc_q8(input logic signed [PRD_W-1:0] p);
      logic signed [PRD_W-1:0] bias;
      logic signed [PRD_W-1:0] biased;
      bias = '0;
      if (p[PRD_W-1]) begin
         bias = {{(PRD_W-8){1'b0}}, 8'hFF};
      end
      biased = p + bias;
      return biased[PRD_W-1:8];
   endfunction

   function automatic logic signed [ACC_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
      logic [SUM_W-ACC_W:0] top;
      top = v[SUM_W-1:ACC_W-1];
      if (top == '0 || top == '1) begin
         return v[ACC_W-1:0];
      end else if (v[SUM_W-1]) begin
         return {1'b1, {(ACC_W-1){1'b0}}};
      end else begin
         return {1'b0, {(ACC_W-1){1'b1}}};
      end
   endfunction

   always_comb begin
      ch_idx = ChW'(item.channel);
      gains  = cfg.gains[item.channel];

      err          = ERR_W'($signed(item.target)) - ERR_W'($signed(item.encoder));
      sum_wide     = SUM_W'(error_sum_ff[ch_idx]) + SUM_W'(err);
      error_sum_in = sat32(sum_wide);
      diff         = DIFF_W'(err) - DIFF_W'(last_error_ff[ch_idx]);

      prod_p = PRD_W'($signed(gains.kp)) * PRD_W'(err);
      prod_i = PRD_W'($signed(gains.ki)) * PRD_W'(error_sum_in);
      prod_d = PRD_W'($signed(gains.kd)) * PRD_W'(diff);

      accum_wide = SUM_W'(accum_ff[ch_idx]) + SUM_W'(trunc_q8(prod_p))
                 + SUM_W'(trunc_q8(prod_i)) + SUM_W'(trunc_q8(prod_d));
      accum_in   = sat32(accum_wide);

      lim_s = $signed({1'b0, cfg.drive_limit});
      lim_w = ACC_W'(lim_s);
      if (accum_in > lim_w) begin
         drive = lim_s;
      end else if (accum_in < -lim_w) begin
         drive = -lim_s;
      end else begin
         drive = accum_in[DRIVE_W-1:0];
      end

      mag        = drive[DRIVE_W-1] ? DRIVE_W'(-drive) : drive;
      far        = $signed({1'b0, cfg.pwm_center}) - $signed({1'b0, mag});
      far_sat    = far[CENTER_W] ? '0 : far[CENTER_W-1:0];
      far_on_one = item.channel ^ drive[DRIVE_W-1];

      result.out_channel = item.channel;
      result.drive       = drive;
      result.compare_one = far_on_one ? far_sat : cfg.pwm_center;
      result.compare_two = far_on_one ? cfg.pwm_center : far_sat;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            last_error_ff[i] <= '0;
            error_sum_ff[i]  <= '0;
            accum_ff[i]      <= '0;
         end
      end else if (advance) begin
         last_error_ff[ch_idx] <= err;
         error_sum_ff[ch_idx]  <= error_sum_in;
         accum_ff[ch_idx]      <= accum_in;
      end
   end

   `DMV_ASSERT(a_last_error_tracks, clock, reset, advance |=> last_error_ff[$past(ch_idx)] == $past(err), "last error not updated for served channel")
   `DMV_ASSERT(a_drive_in_limit, clock, reset, advance |-> ($signed(result.drive) <= lim_s && $signed(result.drive) >= -lim_s), "drive outside limit")
   `DMV_ASSERT(a_one_side_centered, clock, reset, advance |-> (result.compare_one == cfg.pwm_center || result.compare_two == cfg.pwm_center), "neither bridge side at center")

endmodule
